[sv/chse_pkg.sv]
// Shared constants for the cubic Hermite spline evaluator.
// Holds the Q16.16 format, table depth and register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chse_pkg;

  localparam int MAX_KNOTS = 256;
  localparam int KNOT_AW   = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int FRAC_W    = 16;
  localparam int ONE_Q16   = 1 << FRAC_W;
  localparam int T_W       = FRAC_W + 1;
  localparam int H_W       = T_W + 3;

  localparam logic [1:0] REG_X_START    = 2'd0;
  localparam logic [1:0] REG_SPACING    = 2'd1;
  localparam logic [1:0] REG_RECIPROCAL = 2'd2;
  localparam logic [1:0] REG_KNOT_COUNT = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

endpackage

`default_nettype wire

[sv/cubic_hermite_spline_eval.sv]
// Cubic Hermite spline evaluator on uniform knots, eight-stage pipeline.
// Depends on chse_pkg for the number format, table depth and register codes.
// A request passes through the stage registers one to eight; its result is held in the stage-eight register.
// Throughput: one request per cycle while out_ready is high; a full stage holds only while the stage after it holds.
// The knot tables are read at two addresses in stage four and written there too.
// Reset clears the valid bits and sets the configuration to its defaults; the tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module cubic_hermite_spline_eval
  import chse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic [7:0]         in_knot_index,
  input  wire logic signed [31:0] in_knot_value,
  input  wire logic signed [31:0] in_knot_slope,
  input  wire logic signed [31:0] in_query_x,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_spline_value,
  output logic                    out_out_of_range,
  output logic                    out_write_done
);

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  logic signed [31:0] x_start_r;
  logic [30:0]        spacing_r;
  logic [30:0]        recip_r;
  logic [8:0]         count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r <= '0;
      spacing_r <= 31'(ONE_Q16);
      recip_r   <= 31'(ONE_Q16);
      count_r   <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_START:    x_start_r <= $signed(cfg_wdata);
        REG_SPACING:    spacing_r <= cfg_wdata[30:0];
        REG_RECIPROCAL: recip_r   <= cfg_wdata[30:0];
        REG_KNOT_COUNT: count_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (32'(count_r) < 32'd2) begin
      n_eff = CNT_W'(2);
    end else if (32'(count_r) > 32'(MAX_KNOTS)) begin
      n_eff = CNT_W'(MAX_KNOTS);
    end else begin
      n_eff = CNT_W'(count_r);
    end
  end

  logic [8:1] v_r;
  logic [9:1] en;

  always_comb begin
    en[9] = out_ready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[8];

  // Stage 1: offset from the first knot.
  logic               s1_op_r;
  logic [7:0]         s1_idx_r;
  logic signed [31:0] s1_val_r;
  logic signed [31:0] s1_slope_r;
  logic signed [32:0] s1_d_r;
  logic signed [32:0] s1_d_nxt;

  assign s1_d_nxt = 33'(in_query_x) - 33'(x_start_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op_r    <= in_opcode;
      s1_idx_r   <= in_knot_index;
      s1_val_r   <= in_knot_value;
      s1_slope_r <= in_knot_slope;
      s1_d_r     <= s1_d_nxt;
    end
  end

  // Stage 2: position in units of knot spacing, Q32.32.
  logic               s2_op_r;
  logic [7:0]         s2_idx_r;
  logic signed [31:0] s2_val_r;
  logic signed [31:0] s2_slope_r;
  logic signed [63:0] s2_pos_r;
  logic signed [31:0] recip_s;
  logic signed [63:0] s2_pos_nxt;

  assign recip_s    = $signed({1'b0, recip_r});
  assign s2_pos_nxt = 64'(s1_d_r) * 64'(recip_s);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_op_r    <= s1_op_r;
      s2_idx_r   <= s1_idx_r;
      s2_val_r   <= s1_val_r;
      s2_slope_r <= s1_slope_r;
      s2_pos_r   <= s2_pos_nxt;
    end
  end

  // Stage 3: segment index and fraction with clamping.
  logic               s3_op_r;
  logic [7:0]         s3_idx_r;
  logic signed [31:0] s3_val_r;
  logic signed [31:0] s3_slope_r;
  logic [KNOT_AW-1:0] s3_seg_r;
  logic [T_W-1:0]     s3_t_r;
  logic               s3_oor_r;
  logic [KNOT_AW-1:0] seg_nxt;
  logic [T_W-1:0]     t_nxt;
  logic               oor_nxt;
  logic [31:0]        seg_hi;
  logic [31:0]        n_m1;
  logic [31:0]        n_m2;

  assign seg_hi = s2_pos_r[63:32];
  assign n_m1   = 32'(n_eff) - 32'd1;
  assign n_m2   = 32'(n_eff) - 32'd2;

  always_comb begin
    if (seg_hi[31]) begin
      seg_nxt = '0;
      t_nxt   = '0;
      oor_nxt = 1'b1;
    end else if (seg_hi >= n_m1) begin
      seg_nxt = n_m2[KNOT_AW-1:0];
      t_nxt   = T_W'(ONE_Q16);
      oor_nxt = !(seg_hi == n_m1 && s2_pos_r[31:0] == 32'd0);
    end else begin
      seg_nxt = seg_hi[KNOT_AW-1:0];
      t_nxt   = {1'b0, s2_pos_r[31:16]};
      oor_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_op_r    <= s2_op_r;
      s3_idx_r   <= s2_idx_r;
      s3_val_r   <= s2_val_r;
      s3_slope_r <= s2_slope_r;
      s3_seg_r   <= seg_nxt;
      s3_t_r     <= t_nxt;
      s3_oor_r   <= oor_nxt;
    end
  end

  // Stage 4: table access and t squared.
  logic signed [31:0] values_mem [MAX_KNOTS];
  logic signed [31:0] slopes_mem [MAX_KNOTS];
  logic [31:0]        widx;
  logic               wr_ok;
  logic [KNOT_AW-1:0] seg_next;

  assign widx     = 32'(s3_idx_r);
  assign wr_ok    = widx < 32'(MAX_KNOTS);
  assign seg_next = s3_seg_r + KNOT_AW'(1);

  logic               s4_op_r;
  logic               s4_oor_r;
  logic [T_W-1:0]     s4_t_r;
  logic [T_W-1:0]     s4_t2_r;
  logic signed [31:0] s4_p0_r;
  logic signed [31:0] s4_p1_r;
  logic signed [31:0] s4_m0_r;
  logic signed [31:0] s4_m1_r;
  logic [2*T_W-1:0]   tt;

  assign tt = (2*T_W)'(s3_t_r) * (2*T_W)'(s3_t_r);

  always_ff @(posedge clk) begin
    if (v_r[3] && en[4]) begin
      if (s3_op_r == OP_WRITE) begin
        if (wr_ok) begin
          values_mem[widx[KNOT_AW-1:0]] <= s3_val_r;
          slopes_mem[widx[KNOT_AW-1:0]] <= s3_slope_r;
        end
      end else begin
        s4_p0_r <= values_mem[s3_seg_r];
        s4_p1_r <= values_mem[seg_next];
        s4_m0_r <= slopes_mem[s3_seg_r];
        s4_m1_r <= slopes_mem[seg_next];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_op_r  <= s3_op_r;
      s4_oor_r <= s3_oor_r;
      s4_t_r   <= s3_t_r;
      s4_t2_r  <= T_W'(tt >> FRAC_W);
    end
  end

  // Stage 5: t cubed.
  logic               s5_op_r;
  logic               s5_oor_r;
  logic [T_W-1:0]     s5_t_r;
  logic [T_W-1:0]     s5_t2_r;
  logic [T_W-1:0]     s5_t3_r;
  logic signed [31:0] s5_p0_r;
  logic signed [31:0] s5_p1_r;
  logic signed [31:0] s5_m0_r;
  logic signed [31:0] s5_m1_r;
  logic [2*T_W-1:0]   ttt;

  assign ttt = (2*T_W)'(s4_t2_r) * (2*T_W)'(s4_t_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_op_r  <= s4_op_r;
      s5_oor_r <= s4_oor_r;
      s5_t_r   <= s4_t_r;
      s5_t2_r  <= s4_t2_r;
      s5_t3_r  <= T_W'(ttt >> FRAC_W);
      s5_p0_r  <= s4_p0_r;
      s5_p1_r  <= s4_p1_r;
      s5_m0_r  <= s4_m0_r;
      s5_m1_r  <= s4_m1_r;
    end
  end

  // Stage 6: basis weights times knot values and slopes.
  logic signed [H_W-1:0]    t_s;
  logic signed [H_W-1:0]    t2_s;
  logic signed [H_W-1:0]    t3_s;
  logic signed [H_W-1:0]    h00;
  logic signed [H_W-1:0]    h10;
  logic signed [H_W-1:0]    h01;
  logic signed [H_W-1:0]    h11;
  logic signed [H_W+31:0]   pr00_nxt;
  logic signed [H_W+31:0]   pr01_nxt;
  logic signed [H_W+31:0]   pr10_nxt;
  logic signed [H_W+31:0]   pr11_nxt;

  assign t_s  = $signed(H_W'(s5_t_r));
  assign t2_s = $signed(H_W'(s5_t2_r));
  assign t3_s = $signed(H_W'(s5_t3_r));
  assign h00  = H_W'(2 * t3_s - 3 * t2_s + ONE_Q16);
  assign h10  = H_W'(t3_s - 2 * t2_s + t_s);
  assign h01  = H_W'(3 * t2_s - 2 * t3_s);
  assign h11  = H_W'(t3_s - t2_s);

  assign pr00_nxt = (H_W+32)'(h00) * (H_W+32)'(s5_p0_r);
  assign pr01_nxt = (H_W+32)'(h01) * (H_W+32)'(s5_p1_r);
  assign pr10_nxt = (H_W+32)'(h10) * (H_W+32)'(s5_m0_r);
  assign pr11_nxt = (H_W+32)'(h11) * (H_W+32)'(s5_m1_r);

  logic                   s6_op_r;
  logic                   s6_oor_r;
  logic signed [H_W+31:0] s6_pr00_r;
  logic signed [H_W+31:0] s6_pr01_r;
  logic signed [H_W+31:0] s6_pr10_r;
  logic signed [H_W+31:0] s6_pr11_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_op_r   <= s5_op_r;
      s6_oor_r  <= s5_oor_r;
      s6_pr00_r <= pr00_nxt;
      s6_pr01_r <= pr01_nxt;
      s6_pr10_r <= pr10_nxt;
      s6_pr11_r <= pr11_nxt;
    end
  end

  // Stage 7: slope terms scaled by the knot spacing.
  logic signed [31:0]         spacing_s;
  logic signed [31:0]         q0;
  logic signed [31:0]         q1;
  logic signed [63:0]         b0_nxt;
  logic signed [63:0]         b1_nxt;
  logic signed [H_W+15:0]     a0_nxt;
  logic signed [H_W+15:0]     a1_nxt;

  // The slope weights stay below a sixth of one, so the shifted slope
  // products fit in 32 bits.
  assign spacing_s = $signed({1'b0, spacing_r});
  assign q0        = $signed(s6_pr10_r[47:16]);
  assign q1        = $signed(s6_pr11_r[47:16]);
  assign b0_nxt    = 64'(q0) * 64'(spacing_s);
  assign b1_nxt    = 64'(q1) * 64'(spacing_s);
  assign a0_nxt    = $signed(s6_pr00_r[H_W+31:16]);
  assign a1_nxt    = $signed(s6_pr01_r[H_W+31:16]);

  logic                   s7_op_r;
  logic                   s7_oor_r;
  logic signed [H_W+15:0] s7_a0_r;
  logic signed [H_W+15:0] s7_a1_r;
  logic signed [63:0]     s7_b0_r;
  logic signed [63:0]     s7_b1_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_op_r  <= s6_op_r;
      s7_oor_r <= s6_oor_r;
      s7_a0_r  <= a0_nxt;
      s7_a1_r  <= a1_nxt;
      s7_b0_r  <= b0_nxt;
      s7_b1_r  <= b1_nxt;
    end
  end

  // Stage 8: sum, saturation and the result register.
  logic signed [63:0] sum;
  logic signed [31:0] sat_nxt;

  assign sum = 64'(s7_a0_r) + 64'(s7_a1_r) + (s7_b0_r >>> FRAC_W) + (s7_b1_r >>> FRAC_W);

  always_comb begin
    if (sum > SAT_HI) begin
      sat_nxt = SAT_HI[31:0];
    end else if (sum < SAT_LO) begin
      sat_nxt = SAT_LO[31:0];
    end else begin
      sat_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      if (s7_op_r == OP_WRITE) begin
        out_spline_value <= '0;
        out_out_of_range <= 1'b0;
        out_write_done   <= 1'b1;
      end else begin
        out_spline_value <= sat_nxt;
        out_out_of_range <= s7_oor_r;
        out_write_done   <= 1'b0;
      end
    end
  end

  a_write_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_done) |-> (out_spline_value == 32'sd0 && !out_out_of_range))
    else $error("Write acknowledge carries a value or range flag.");

  a_seg_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && s3_op_r == OP_EVAL) |-> (32'(s3_seg_r) <= n_m2))
    else $error("Segment index beyond the last usable segment.");

  a_t_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && s3_op_r == OP_EVAL) |-> (32'(s3_t_r) <= 32'(ONE_Q16)))
    else $error("Fraction exceeds one.");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[8] && v_r[7] && !out_ready) |=> (v_r[8] && v_r[7]))
    else $error("Pipeline lost a request while stalled.");

endmodule

`default_nettype wire
